>>> design/fwd_pkg.sv
// ----------------------------------------------------------------------------
// fwd_pkg
// Shared constants, register codes and the binary32 round-and-pack function.
// ----------------------------------------------------------------------------
package fwd_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC00000;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT_LENGTH = 2'd0,
        CFG_COL_COUNT  = 2'd1,
        CFG_ROW_COUNT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic        done;
        logic [31:0] index;
    } stage_ctrl_t;

    // m[25] is the leading one, m[24:2] fraction, m[1] guard, m[0] sticky.
    // Value is 1.f * 2^(e-127); e <= 0 denormalizes.
    function automatic logic [31:0] round_pack(
        input logic               s,
        input logic signed [9:0]  e,
        input logic [25:0]        m
    );
        logic signed [9:0] sh;
        logic [4:0]        sh5;
        logic [51:0]       wide;
        logic [7:0]        ef;
        logic [22:0]       frac;
        logic              g;
        logic              st;
        logic [30:0]       mag;
        logic              inc;
        sh   = 10'sd1 - e;
        sh5  = 5'd0;
        wide = '0;
        ef   = 8'd0;
        frac = m[24:2];
        g    = m[1];
        st   = m[0];
        if (e >= 10'sd1)
        begin
            ef = e[7:0];
        end
        else
        begin
            sh5  = (sh > 10'sd27) ? 5'd27 : sh[4:0];
            wide = {m, 26'd0} >> sh5;
            frac = wide[50:28];
            g    = wide[27];
            st   = |wide[26:0];
        end
        mag = {ef, frac};
        inc = g & (st | mag[0]);
        mag = mag + {30'd0, inc};
        if (e >= 10'sd255)
        begin
            round_pack = {s, 8'hFF, 23'd0};
        end
        else
        begin
            round_pack = {s, mag};
        end
    endfunction

endpackage

>>> design/fwd_in_if.sv
// ----------------------------------------------------------------------------
// fwd_in_if
// Input channel: one weight/activation pair per transaction.
// ----------------------------------------------------------------------------
interface fwd_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] weight_fp24;
    logic [31:0] activation;

    modport source (output valid, output weight_fp24, output activation, input ready);
    modport sink   (input valid, input weight_fp24, input activation, output ready);
endinterface

>>> design/fwd_out_if.sv
// ----------------------------------------------------------------------------
// fwd_out_if
// Result channel: one finished dot product per transaction.
// ----------------------------------------------------------------------------
interface fwd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_sum;
    logic [31:0] out_index;
    logic        matrix_done;

    modport source (output valid, output dot_sum, output out_index, output matrix_done,
                    input ready);
    modport sink   (input valid, input dot_sum, input out_index, input matrix_done,
                    output ready);
endinterface

>>> design/fwd_cfg_if.sv
// ----------------------------------------------------------------------------
// fwd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fwd_cfg_if #(
    parameter int DIM_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [fwd_pkg::CFG_IDX_W-1:0] index;
    logic [DIM_WIDTH-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/fp24_weight_dot_product_accumulator.sv
// ----------------------------------------------------------------------------
// fp24_weight_dot_product_accumulator
// Streaming dot-product engine: FP24 weight times binary32 activation, summed.
// ----------------------------------------------------------------------------
// Channels:
//   pair   - one weight_fp24/activation transaction per cycle when ready.
//   result - dot_sum, out_index and matrix_done once per dot_length pairs.
//   cfg    - register writes: 0 dot_length, 1 col_count, 2 row_count;
//            other indexes are ignored. Always ready; write only when idle.
// Throughput: one pair per cycle while not stalled; the accumulator add is
//   combinational. Path: w_reg/a_reg, multiplier registers, then acc_reg;
//   the result of a closing pair is registered with its acc_reg update.
// Stall: the pipeline advances only while the result register is empty or
//   being taken; pair.ready drops while a result waits unread.
// Reset: sum +0.0, counters zero, all registers 1, pipeline empty.
// A register value of zero acts as one.
// ----------------------------------------------------------------------------
module fp24_weight_dot_product_accumulator #(
    parameter int DIM_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    fwd_in_if.sink          pair,
    fwd_out_if.source       result,
    fwd_cfg_if.sink         cfg
);

    localparam int POS_W = 2 * DIM_WIDTH;

    logic [DIM_WIDTH-1:0] dot_length_reg, col_count_reg, row_count_reg;
    logic [DIM_WIDTH-1:0] len, colx, rowx;
    logic [DIM_WIDTH-1:0] pair_cnt_reg, pair_cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next, total;
    logic                 is_last, is_done, advance, in_fire;

    fwd_pkg::stage_ctrl_t s1_reg, s2_reg, s3_reg, s1_next;
    logic [31:0]          w_reg, a_reg, prod;
    logic [31:0]          acc_reg, acc_sum;
    logic                 out_valid_reg;
    logic [31:0]          out_sum_reg, out_index_reg;
    logic                 out_done_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_length_reg <= DIM_WIDTH'(1);
            col_count_reg  <= DIM_WIDTH'(1);
            row_count_reg  <= DIM_WIDTH'(1);
        end
        else if (cfg.valid)
        begin
            unique case (fwd_pkg::cfg_reg_t'(cfg.index))
                fwd_pkg::CFG_DOT_LENGTH: dot_length_reg <= cfg.data;
                fwd_pkg::CFG_COL_COUNT:  col_count_reg  <= cfg.data;
                fwd_pkg::CFG_ROW_COUNT:  row_count_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    assign advance    = !out_valid_reg || result.ready;
    assign pair.ready = advance;
    assign in_fire    = pair.valid && advance;

    always_comb
    begin
        len      = (dot_length_reg == '0) ? DIM_WIDTH'(1) : dot_length_reg;
        colx     = (col_count_reg == '0) ? DIM_WIDTH'(1) : col_count_reg;
        rowx     = (row_count_reg == '0) ? DIM_WIDTH'(1) : row_count_reg;
        total    = POS_W'(colx) * POS_W'(rowx);
        is_last  = ({1'b0, pair_cnt_reg} + (DIM_WIDTH+1)'(1)) >= {1'b0, len};
        is_done  = ({1'b0, pos_reg} + (POS_W+1)'(1)) >= {1'b0, total};
        pair_cnt_next = is_last ? '0 : pair_cnt_reg + DIM_WIDTH'(1);
        pos_next = is_last ? (is_done ? '0 : pos_reg + POS_W'(1)) : pos_reg;
        s1_next.valid = in_fire;
        s1_next.last  = is_last;
        s1_next.done  = is_done;
        s1_next.index = 32'(pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_cnt_reg  <= '0;
            pos_reg       <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_fire)
            begin
                pair_cnt_reg <= pair_cnt_next;
                pos_reg      <= pos_next;
            end
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            if (s3_reg.valid)
            begin
                acc_reg <= s3_reg.last ? 32'd0 : acc_sum;
            end
            out_valid_reg <= s3_reg.valid && s3_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w_reg <= {pair.weight_fp24, 8'd0};
            a_reg <= pair.activation;
            if (s3_reg.valid && s3_reg.last)
            begin
                out_sum_reg   <= acc_sum;
                out_index_reg <= s3_reg.index;
                out_done_reg  <= s3_reg.done;
            end
        end
    end

    fwd_mul u_mul (
        .clk  (clk),
        .en   (advance),
        .a    (w_reg),
        .b    (a_reg),
        .prod (prod)
    );

    fwd_add u_add (
        .a   (acc_reg),
        .b   (prod),
        .sum (acc_sum)
    );

    assign result.valid       = out_valid_reg;
    assign result.dot_sum     = out_sum_reg;
    assign result.out_index   = out_index_reg;
    assign result.matrix_done = out_done_reg;

`ifndef SYNTHESIS
    a_acc_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        (&acc_reg[30:23]) && (|acc_reg[22:0]) |-> acc_reg == fwd_pkg::CANON_NAN)
        else $error("running sum holds a non-canonical NaN");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s3_reg.valid && s3_reg.last |=> acc_reg == 32'd0)
        else $error("running sum not cleared after a result");

    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_last && is_done |=> pos_reg == '0)
        else $error("result position did not wrap after the last result");

    a_pair_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_last |=> pair_cnt_reg == '0)
        else $error("pair count not cleared at end of dot product");
`endif

endmodule

>>> design/fwd_mul.sv
// ----------------------------------------------------------------------------
// fwd_mul
// Two-stage binary32 multiplier, round to nearest even.
// ----------------------------------------------------------------------------
module fwd_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] prod
);

    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [23:0]       sig_a, sig_b;
    logic [7:0]        ex_a, ex_b;

    logic [47:0]       p_reg;
    logic signed [9:0] esum_reg;
    logic              sgn_reg;
    logic              spec_reg;
    logic [31:0]       spec_val_reg;
    logic [31:0]       spec_val;

    logic [5:0]        lz;
    logic [47:0]       pn;
    logic signed [9:0] e_n;
    logic [31:0]       prod_reg;

    always_comb
    begin
        a_nan  = (&a[30:23]) & (|a[22:0]);
        b_nan  = (&b[30:23]) & (|b[22:0]);
        a_inf  = (&a[30:23]) & ~(|a[22:0]);
        b_inf  = (&b[30:23]) & ~(|b[22:0]);
        a_zero = ~(|a[30:0]);
        b_zero = ~(|b[30:0]);
        sgn    = a[31] ^ b[31];
        sig_a  = {|a[30:23], a[22:0]};
        sig_b  = {|b[30:23], b[22:0]};
        ex_a   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        ex_b   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            spec_val = fwd_pkg::CANON_NAN;
        end
        else if (a_inf || b_inf)
        begin
            spec_val = {sgn, 8'hFF, 23'd0};
        end
        else
        begin
            spec_val = {sgn, 31'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg        <= sig_a * sig_b;
            esum_reg     <= $signed({2'b00, ex_a}) + $signed({2'b00, ex_b}) - 10'sd126;
            sgn_reg      <= sgn;
            spec_reg     <= a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
            spec_val_reg <= spec_val;
        end
    end

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (p_reg[i])
            begin
                lz = 6'(47 - i);
            end
        end
        pn  = p_reg << lz;
        e_n = esum_reg - $signed({4'd0, lz});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= spec_reg ? spec_val_reg
                                 : fwd_pkg::round_pack(sgn_reg, e_n, {pn[47:23], |pn[22:0]});
        end
    end

    assign prod = prod_reg;

endmodule

>>> design/fwd_add.sv
// ----------------------------------------------------------------------------
// fwd_add
// Binary32 adder, round to nearest even; every NaN result is canonical.
// ----------------------------------------------------------------------------
module fwd_add (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum
);

    logic              a_nan, b_nan, a_inf, b_inf;
    logic              swap;
    logic [31:0]       x, y;
    logic [7:0]        ex, ey, d;
    logic [4:0]        dsh;
    logic [27:0]       x28, y28, yal, s, sn;
    logic [54:0]       yw;
    logic [4:0]        lz;
    logic signed [9:0] e;

    always_comb
    begin
        a_nan = (&a[30:23]) & (|a[22:0]);
        b_nan = (&b[30:23]) & (|b[22:0]);
        a_inf = (&a[30:23]) & ~(|a[22:0]);
        b_inf = (&b[30:23]) & ~(|b[22:0]);
        swap  = b[30:0] > a[30:0];
        x     = swap ? b : a;
        y     = swap ? a : b;
        ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d     = ex - ey;
        dsh   = (d > 8'd27) ? 5'd27 : d[4:0];
        x28   = {1'b0, |x[30:23], x[22:0], 3'd0};
        y28   = {1'b0, |y[30:23], y[22:0], 3'd0};
        yw    = {y28, 27'd0} >> dsh;
        yal   = {yw[54:28], yw[27] | (|yw[26:0])};
        s     = (x[31] ^ y[31]) ? (x28 - yal) : (x28 + yal);
        lz    = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (s[i])
            begin
                lz = 5'(26 - i);
            end
        end
        if (s[27])
        begin
            sn = {1'b0, s[27:2], s[1] | s[0]};
            e  = $signed({2'b00, ex}) + 10'sd1;
        end
        else
        begin
            sn = s << lz;
            e  = $signed({2'b00, ex}) - $signed({5'd0, lz});
        end
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31])))
        begin
            sum = fwd_pkg::CANON_NAN;
        end
        else if (a_inf)
        begin
            sum = a;
        end
        else if (b_inf)
        begin
            sum = b;
        end
        else if (s == 28'd0)
        begin
            sum = {a[31] & b[31], 31'd0};
        end
        else
        begin
            sum = fwd_pkg::round_pack(x[31], e, {sn[26:2], |sn[1:0]});
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the FP24-weight dot-product accumulator.
// Drives weight/activation pairs and register writes, predicts each finished
// dot product with bit-exact binary32 multiply and add, and checks results.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fwd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int                            WATCHDOG_LIMIT = 20000;
    localparam int                            DRAIN_CYCLES   = 10;

    typedef struct {
        logic [31:0] dot_sum;
        logic [31:0] out_index;
        logic        matrix_done;
    } dot_result_t;

    class dot_tracker;
        logic [15:0]  dot_length;
        logic [15:0]  col_count;
        logic [15:0]  row_count;
        logic [31:0]  acc;
        logic [15:0]  pairs_done;
        longint       position;
        dot_result_t  pending[$];
        int           errors;

        function new();
            dot_length = 16'd1;
            col_count  = 16'd1;
            row_count  = 16'd1;
            acc        = 32'd0;
            pairs_done = 16'd0;
            position   = 0;
            errors     = 0;
        endfunction

        function bit is_nan(logic [31:0] x);
            return x[30:23] == 8'hFF && x[22:0] != 0;
        endfunction

        function bit is_inf(logic [31:0] x);
            return x[30:23] == 8'hFF && x[22:0] == 0;
        endfunction

        function void unpack(logic [31:0] x, output int e, output logic [63:0] m);
            if (x[30:23] == 8'd0)
            begin
                m = {41'd0, x[22:0]};
                e = -149;
            end
            else
            begin
                m = {40'd0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        // value = m * 2^e, rounded to nearest even
        function logic [31:0] round_f32(bit s, int e, logic [63:0] m);
            int          p;
            int          lsb_e;
            int          sh;
            logic [63:0] q;
            bit          g;
            bit          st;
            longint      t;
            if (m == 0)
                return {s, 31'd0};
            p = 63;
            while (!m[p])
                p--;
            lsb_e = p + e - 23;
            if (lsb_e < -149)
                lsb_e = -149;
            sh = lsb_e - e;
            if (sh <= 0)
            begin
                q  = m << (-sh);
                g  = 0;
                st = 0;
            end
            else if (sh > 64)
            begin
                q  = 0;
                g  = 0;
                st = 1;
            end
            else if (sh == 64)
            begin
                q  = 0;
                g  = m[63];
                st = |m[62:0];
            end
            else
            begin
                q  = m >> sh;
                g  = m[sh-1];
                st = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
            end
            if (g && (st || q[0]))
                q++;
            t = (longint'(lsb_e + 149) << 23) + longint'(q);
            if (t >= 64'h7F800000)
                return {s, 8'hFF, 23'd0};
            return {s, t[30:0]};
        endfunction

        function logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
            bit          s;
            int          ea;
            int          eb;
            logic [63:0] ma;
            logic [63:0] mb;
            s = a[31] ^ b[31];
            if (is_nan(a) || is_nan(b))
                return fwd_pkg::CANON_NAN;
            if (is_inf(a) || is_inf(b))
            begin
                if (a[30:0] == 0 || b[30:0] == 0)
                    return fwd_pkg::CANON_NAN;
                return {s, 8'hFF, 23'd0};
            end
            unpack(a, ea, ma);
            unpack(b, eb, mb);
            if (ma == 0 || mb == 0)
                return {s, 31'd0};
            return round_f32(s, ea + eb, ma * mb);
        endfunction

        function logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
            int          ea;
            int          eb;
            int          d;
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] xh;
            logic [63:0] xl;
            logic [63:0] r;
            logic [31:0] tmp;
            bit          s;
            if (is_nan(a) || is_nan(b))
                return fwd_pkg::CANON_NAN;
            if (is_inf(a) && is_inf(b) && a[31] != b[31])
                return fwd_pkg::CANON_NAN;
            if (is_inf(a))
                return a;
            if (is_inf(b))
                return b;
            if (a[30:0] == 0 && b[30:0] == 0)
                return {a[31] & b[31], 31'd0};
            if (a[30:0] == 0)
                return b;
            if (b[30:0] == 0)
                return a;
            unpack(a, ea, ma);
            unpack(b, eb, mb);
            if (ea < eb)
            begin
                tmp = a;
                a   = b;
                b   = tmp;
                unpack(a, ea, ma);
                unpack(b, eb, mb);
            end
            d  = ea - eb;
            xh = ma << 39;
            if (d <= 39)
                xl = mb << (39 - d);
            else if (d - 39 >= 64)
                xl = 64'd1;
            else
            begin
                xl = mb >> (d - 39);
                if ((mb & ((64'd1 << (d - 39)) - 64'd1)) != 0)
                    xl[0] = 1'b1;
            end
            if (a[31] == b[31])
            begin
                r = xh + xl;
                s = a[31];
            end
            else if (xh >= xl)
            begin
                r = xh - xl;
                s = a[31];
            end
            else
            begin
                r = xl - xh;
                s = b[31];
            end
            if (r == 0)
                return 32'd0;
            return round_f32(s, ea - 39, r);
        endfunction

        function void write_reg(logic [fwd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                fwd_pkg::CFG_DOT_LENGTH: dot_length = val;
                fwd_pkg::CFG_COL_COUNT:  col_count  = val;
                fwd_pkg::CFG_ROW_COUNT:  row_count  = val;
                default:                 ;
            endcase
        endfunction

        function void note_pair(logic [23:0] w, logic [31:0] act);
            longint      len;
            longint      total;
            dot_result_t r;
            acc = f32_add(acc, f32_mul({w, 8'd0}, act));
            len = (dot_length == 0) ? 1 : longint'(dot_length);
            if (longint'(pairs_done) + 1 < len)
            begin
                pairs_done++;
                return;
            end
            total = ((col_count == 0) ? 1 : longint'(col_count)) *
                    ((row_count == 0) ? 1 : longint'(row_count));
            r.dot_sum   = acc;
            r.out_index = position[31:0];
            if (position + 1 >= total)
            begin
                r.matrix_done = 1'b1;
                position      = 0;
            end
            else
            begin
                r.matrix_done = 1'b0;
                position++;
            end
            pending.push_back(r);
            acc        = 32'd0;
            pairs_done = 16'd0;
        endfunction

        function void check_result(logic [31:0] s, logic [31:0] idx, logic done);
            dot_result_t x;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result sum %h index %0d done %b",
                         $time, s, idx, done);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (s !== x.dot_sum)
            begin
                $display("%0t: dot_sum expected %h actual %h", $time, x.dot_sum, s);
                errors++;
            end
            if (idx !== x.out_index)
            begin
                $display("%0t: out_index expected %0d actual %0d",
                         $time, x.out_index, idx);
                errors++;
            end
            if (done !== x.matrix_done)
            begin
                $display("%0t: matrix_done expected %b actual %b",
                         $time, x.matrix_done, done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fwd_in_if            pair_if();
    fwd_out_if           res_if();
    fwd_cfg_if #(.DIM_WIDTH(16)) cfg_bus();

    fp24_weight_dot_product_accumulator #(.DIM_WIDTH(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_if),
        .result (res_if),
        .cfg    (cfg_bus)
    );

    dot_tracker tracker;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_cycles;
    int         quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            tracker.check_result(res_if.dot_sum, res_if.out_index, res_if.matrix_done);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((pair_if.valid && pair_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_bus.valid && cfg_bus.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fp24_weight_dot_product_accumulator regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(logic [fwd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        tracker.write_reg(idx, val);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(logic [15:0] dl, logic [15:0] cc, logic [15:0] rr);
        cfg_write(fwd_pkg::CFG_DOT_LENGTH, dl);
        cfg_write(fwd_pkg::CFG_COL_COUNT, cc);
        cfg_write(fwd_pkg::CFG_ROW_COUNT, rr);
    endtask

    task automatic send_pair(logic [23:0] w, logic [31:0] act);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_if.valid <= 1'b0;
            @(posedge clk);
        end
        pair_if.valid       <= 1'b1;
        pair_if.weight_fp24 <= w;
        pair_if.activation  <= act;
        @(posedge clk);
        while (!pair_if.ready)
            @(posedge clk);
        tracker.note_pair(w, act);
    endtask

    task automatic settle();
        pair_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_f32();
        logic [31:0] specials[9] = '{32'h00000000, 32'h80000000, 32'h7F800000,
                                     32'hFF800000, 32'h7FC00000, 32'h7F7FFFFF,
                                     32'h00000001, 32'h007FFFFF, 32'h00800000};
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return specials[$urandom_range(8)];
            default: return {1'($urandom), 8'($urandom_range(134, 120)), 23'($urandom)};
        endcase
    endfunction

    task automatic random_phase(logic [15:0] dl, logic [15:0] cc, logic [15:0] rr,
                                int n, int idle, int stall, int hold);
        logic [31:0] w;
        set_dims(dl, cc, rr);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        hold_cycles    = hold;
        repeat (n)
        begin
            w = rand_f32();
            send_pair(w[31:8], rand_f32());
        end
        settle();
    endtask

    logic [55:0] single_pairs[14] = '{
        {24'h000000, 32'h00000000}, {24'hFFFFFF, 32'h3F800000},
        {24'h7F8000, 32'h00000000}, {24'h7F8000, 32'hBF800000},
        {24'h800000, 32'h3F800000}, {24'h7F7FFF, 32'h7F7FFFFF},
        {24'h000001, 32'h3F800000}, {24'h3F8000, 32'h00000001},
        {24'h3F8000, 32'h807FFFFF}, {24'h008000, 32'h00800000},
        {24'h3FC000, 32'h3FC00000}, {24'hFFFFFF, 32'hFFFFFFFF},
        {24'h400000, 32'h7FC00001}, {24'h3F8000, 32'h7F800000}
    };
    logic [55:0] paired_sums[8] = '{
        {24'h3F8000, 32'h3F800000}, {24'hBF8000, 32'h3F800000},
        {24'h7F7FFF, 32'h7F7FFFFF}, {24'h7F7FFF, 32'h7F7FFFFF},
        {24'h7F8000, 32'h3F800000}, {24'hFF8000, 32'h3F800000},
        {24'h3F8000, 32'h4B800000}, {24'h3F8000, 32'h3F800000}
    };

    initial
    begin
        tracker             = new();
        rst_n               = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_cycles         = 0;
        quiet_cycles        = 0;
        pair_if.valid       = 1'b0;
        pair_if.weight_fp24 = '0;
        pair_if.activation  = '0;
        res_if.ready        = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = fwd_pkg::CFG_DOT_LENGTH;
        cfg_bus.data        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (single_pairs[i])
            send_pair(single_pairs[i][55:32], single_pairs[i][31:0]);
        settle();
        cfg_write(CFG_UNUSED_IDX, 16'($urandom));
        cfg_write(fwd_pkg::CFG_DOT_LENGTH, 16'd2);
        foreach (paired_sums[i])
            send_pair(paired_sums[i][55:32], paired_sums[i][31:0]);
        settle();

        random_phase(16'd0, 16'd0, 16'd0, 60, 0, 0, 0);
        random_phase(16'd3, 16'd4, 16'd2, 100, 83, 0, 0);
        random_phase(16'd1, 16'd3, 16'd5, 100, 0, 83, 0);
        random_phase(16'd4, 16'd2, 16'd3, 80, 21, 21, 0);
        random_phase(16'd1, 16'd2, 16'd2, 60, 0, 0, 300);
        random_phase(16'd65535, 16'd65535, 16'd65535, 30, 83, 0, 0);
        random_phase(16'd2, 16'd3, 16'd1, 40, 0, 83, 0);
        random_phase(16'd1, 16'd65535, 16'd1, 40, 21, 21, 0);
        random_phase(16'd1, 16'd1, 16'd2, 20, 0, 0, 0);
        random_phase(16'd7, 16'd1, 16'd1, 60, 0, 83, 0);

        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("fp24_weight_dot_product_accumulator regression: pass");
        else
            $display("fp24_weight_dot_product_accumulator regression: fail");
        $finish;
    end
endmodule
